@@ hdl/mae_pkg.sv @@
// Shared types and constants for the max/min affine evaluator.
// Used by the top level, controller and datapath; depends on nothing.
`timescale 1ns / 1ps

package mae_pkg;

  // Default sizes of the row and coordinate stores
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_VARS_DEF = 16;

  // Fixed field widths
  localparam int ROW_CNT_W = 7;   // rows_in_use
  localparam int VAR_CNT_W = 5;   // vars_in_use
  localparam int COEF_W    = 16;  // Q4.12
  localparam int CONST_W   = 32;  // Q8.24
  localparam int PROD_W    = 32;  // Q8.24 exact product
  localparam int RES_W     = 48;  // Q24.24
  localparam int BEST_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VARS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONVEX = 2'd2;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    FUNC_COEF  = 2'd0,
    FUNC_CONST = 2'd1,
    FUNC_POINT = 2'd2,
    FUNC_EVAL  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // One multiply-accumulate slot issued to the datapath
  typedef struct packed {
    logic                 valid;
    logic                 first;      // first slot of a row: start from the constant
    logic                 last;       // last slot of a row: row value complete
    logic                 zero_prod;  // no coordinates in use: product forced to zero
    logic                 first_row;  // row 0: seeds the best value
    logic [ROW_CNT_W-1:0] row;
  } issue_t;

  // Commands from the controller
  typedef struct packed {
    logic load;      // write the accepted load item into its store
    logic out_load;  // capture the result into the output register
    logic no_rows;   // result is the empty answer
  } ctl_cmd_t;

  // Status back from the datapath
  typedef struct packed {
    logic busy;      // slots still in flight or a compare pending
  } dp_status_t;

endpackage

@@ hdl/max_affine_evaluator.sv @@
// Top level of the max/min affine evaluator: ports, configuration registers,
// controller and datapath. Depends on mae_pkg, mae_ctrl and mae_datapath.
`timescale 1ns / 1ps

// Evaluates max (convex_mode = 1) or min over rows r < rows_in_use of
// const(r) + sum_j coef(r,j) * point(j), j < vars_in_use, saturated Q24.24, and
// reports the winning row (lowest index on a tie). Coefficient, constant and
// point loads give no result. An evaluate issues one multiply-accumulate a
// cycle, a slot per clamped row and coordinate (one per row with no
// coordinates in use), through the single coefficient memory read port; then
// the store read, multiply, accumulate and compare stages drain and the
// result is captured once the output register is free. With no rows in use
// the result is offered with no_rows set. The input is not taken while an
// evaluation runs; a finished result waits in the output register while
// further loads are accepted.
// Stores hold no reset value.

module max_affine_evaluator #(
  parameter int MAX_ROWS = mae_pkg::MAX_ROWS_DEF,
  parameter int MAX_VARS = mae_pkg::MAX_VARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // row_index [5:0], var_index [9:6], data_value [41:10], zero pad [47:42]
  input  logic [47:0]                    in_tdata,
  // func [1:0]
  input  logic [1:0]                     in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // result_value [47:0], best_row [53:48], zero pad [55:54]
  output logic [55:0]                    out_tdata,
  // no_rows [0]
  output logic [0:0]                     out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [mae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mae_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  localparam int CA_W = (MAX_ROWS * MAX_VARS > 1) ? $clog2(MAX_ROWS * MAX_VARS) : 1;
  localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int VA_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

  logic [mae_pkg::ROW_CNT_W-1:0] rows_r;
  logic [mae_pkg::VAR_CNT_W-1:0] vars_r;
  logic                          convex_r;

  mae_pkg::issue_t     issue;
  mae_pkg::ctl_cmd_t   cmd;
  mae_pkg::dp_status_t status;
  mae_pkg::func_t      in_func;
  logic [CA_W-1:0]     coef_raddr;
  logic [RA_W-1:0]     const_raddr;
  logic [VA_W-1:0]     point_raddr;
  logic [mae_pkg::RES_W-1:0]  result_value;
  logic [mae_pkg::BEST_W-1:0] best_row;
  logic                       no_rows;

  assign in_func = mae_pkg::func_t'(in_tuser);

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= '0;
      vars_r   <= '0;
      convex_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == mae_pkg::CFG_ROWS) begin
        rows_r <= cfg_wdata[mae_pkg::ROW_CNT_W-1:0];
      end
      if (cfg_index == mae_pkg::CFG_VARS) begin
        vars_r <= cfg_wdata[mae_pkg::VAR_CNT_W-1:0];
      end
      if (cfg_index == mae_pkg::CFG_CONVEX) begin
        convex_r <= cfg_wdata[0];
      end
    end
  end

  mae_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_VARS(MAX_VARS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_func     (in_func),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .rows_in_use (rows_r),
    .vars_in_use (vars_r),
    .issue       (issue),
    .coef_raddr  (coef_raddr),
    .const_raddr (const_raddr),
    .point_raddr (point_raddr),
    .cmd         (cmd),
    .status      (status)
  );

  mae_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_VARS(MAX_VARS)) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .issue        (issue),
    .coef_raddr   (coef_raddr),
    .const_raddr  (const_raddr),
    .point_raddr  (point_raddr),
    .convex_mode  (convex_r),
    .in_func      (in_func),
    .in_row       (in_tdata[5:0]),
    .in_var       (in_tdata[9:6]),
    .in_data      (in_tdata[41:10]),
    .result_value (result_value),
    .best_row     (best_row),
    .no_rows      (no_rows),
    .status       (status)
  );

  assign out_tdata = {2'b00, best_row, result_value};
  assign out_tuser = no_rows;

  // The result is captured only once every slot has left the pipeline
  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !status.busy)
    else $error("result captured while the MAC pipeline is busy");

  // No input transfer while slots are being issued
  a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    issue.valid |-> !in_tready)
    else $error("input ready during evaluation");

  // An evaluate transfer stops further input on the next cycle
  a_eval_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_func == mae_pkg::FUNC_EVAL)) |=> !in_tready)
    else $error("input still ready after an evaluate transfer");

  // Loads are written only when the pipeline is empty
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!status.busy && !issue.valid))
    else $error("store write during evaluation");

endmodule

@@ hdl/mae_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package use.
`timescale 1ns / 1ps

module mae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/mae_ctrl.sv @@
// Controller: handshake, evaluation sequencer and address generation.
// Depends on mae_pkg.
`timescale 1ns / 1ps

module mae_ctrl #(
  parameter int MAX_ROWS = mae_pkg::MAX_ROWS_DEF,
  parameter int MAX_VARS = mae_pkg::MAX_VARS_DEF,
  localparam int CA_W = (MAX_ROWS * MAX_VARS > 1) ? $clog2(MAX_ROWS * MAX_VARS) : 1,
  localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int VA_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  mae_pkg::func_t                 in_func,
  output logic                           in_tready,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [mae_pkg::ROW_CNT_W-1:0]  rows_in_use,
  input  logic [mae_pkg::VAR_CNT_W-1:0]  vars_in_use,
  output mae_pkg::issue_t                issue,
  output logic [CA_W-1:0]                coef_raddr,
  output logic [RA_W-1:0]                const_raddr,
  output logic [VA_W-1:0]                point_raddr,
  output mae_pkg::ctl_cmd_t              cmd,
  input  mae_pkg::dp_status_t            status
);

  mae_pkg::state_t state_r, state_nxt;
  logic [mae_pkg::ROW_CNT_W-1:0] row_r, row_nxt;
  logic [mae_pkg::VAR_CNT_W-1:0] var_r, var_nxt;
  logic [CA_W-1:0]               base_r, base_nxt;
  logic                          no_rows_r, no_rows_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [mae_pkg::ROW_CNT_W-1:0] nr;
  logic [mae_pkg::VAR_CNT_W-1:0] nv;
  logic [mae_pkg::VAR_CNT_W-1:0] slots;
  logic                          in_xfer;
  logic                          slot_last;
  logic                          row_last;

  // Effective counts, clamped to the store sizes
  always_comb begin
    nr    = (32'(rows_in_use) > MAX_ROWS) ? mae_pkg::ROW_CNT_W'(MAX_ROWS) : rows_in_use;
    nv    = (32'(vars_in_use) > MAX_VARS) ? mae_pkg::VAR_CNT_W'(MAX_VARS) : vars_in_use;
    slots = (nv == '0) ? mae_pkg::VAR_CNT_W'(1) : nv;
  end

  assign in_tready  = (state_r == mae_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign slot_last  = (var_r == slots - 1'b1);
  assign row_last   = (row_r == nr - 1'b1);
  assign out_tvalid = out_valid_r;

  // Read addresses of the current slot
  assign coef_raddr  = base_r + CA_W'(var_r);
  assign const_raddr = RA_W'(row_r);
  assign point_raddr = VA_W'(var_r);

  // State register and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mae_pkg::ST_IDLE;
      row_r       <= '0;
      var_r       <= '0;
      base_r      <= '0;
      no_rows_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      var_r       <= var_nxt;
      base_r      <= base_nxt;
      no_rows_r   <= no_rows_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state, slot issue and commands
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    var_nxt       = var_r;
    base_nxt      = base_r;
    no_rows_nxt   = no_rows_r;
    out_valid_nxt = out_valid_r && !out_tready;

    issue           = '0;
    issue.first     = (var_r == '0);
    issue.last      = slot_last;
    issue.zero_prod = (nv == '0);
    issue.first_row = (row_r == '0);
    issue.row       = row_r;

    cmd         = '0;
    cmd.no_rows = no_rows_r;

    unique case (state_r)
      mae_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_func == mae_pkg::FUNC_EVAL) begin
            row_nxt     = '0;
            var_nxt     = '0;
            base_nxt    = '0;
            no_rows_nxt = (nr == '0);
            state_nxt   = (nr == '0) ? mae_pkg::ST_FINISH : mae_pkg::ST_RUN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      mae_pkg::ST_RUN: begin
        issue.valid = 1'b1;
        if (slot_last) begin
          var_nxt  = '0;
          row_nxt  = row_r + 1'b1;
          base_nxt = base_r + CA_W'(MAX_VARS);
          if (row_last) begin
            state_nxt = mae_pkg::ST_DRAIN;
          end
        end else begin
          var_nxt = var_r + 1'b1;
        end
      end
      mae_pkg::ST_DRAIN: begin
        if (!status.busy) begin
          state_nxt = mae_pkg::ST_FINISH;
        end
      end
      mae_pkg::ST_FINISH: begin
        // Wait for the output register to be free
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mae_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mae_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ hdl/mae_datapath.sv @@
// Datapath: coefficient, constant and point stores, MAC pipeline,
// best-row tracking and the result register. Depends on mae_pkg and mae_ram.
`timescale 1ns / 1ps

module mae_datapath #(
  parameter int MAX_ROWS = mae_pkg::MAX_ROWS_DEF,
  parameter int MAX_VARS = mae_pkg::MAX_VARS_DEF,
  localparam int CA_W = (MAX_ROWS * MAX_VARS > 1) ? $clog2(MAX_ROWS * MAX_VARS) : 1,
  localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int VA_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mae_pkg::ctl_cmd_t             cmd,
  input  mae_pkg::issue_t               issue,
  input  logic [CA_W-1:0]               coef_raddr,
  input  logic [RA_W-1:0]               const_raddr,
  input  logic [VA_W-1:0]               point_raddr,
  input  logic                          convex_mode,
  input  mae_pkg::func_t                in_func,
  input  logic [5:0]                    in_row,
  input  logic [3:0]                    in_var,
  input  logic [31:0]                   in_data,
  output logic [mae_pkg::RES_W-1:0]     result_value,
  output logic [mae_pkg::BEST_W-1:0]    best_row,
  output logic                          no_rows,
  output mae_pkg::dp_status_t           status
);

  localparam int RES_W = mae_pkg::RES_W;

  logic                         coef_we, const_we, point_we;
  logic                         row_ok, var_ok;
  logic [CA_W-1:0]              coef_waddr;
  logic [mae_pkg::COEF_W-1:0]   coef_rd, point_rd;
  logic [mae_pkg::CONST_W-1:0]  const_rd;

  // Load decode; out-of-range indexes are dropped
  always_comb begin
    row_ok     = (32'(in_row) < MAX_ROWS);
    var_ok     = (32'(in_var) < MAX_VARS);
    coef_we    = cmd.load && (in_func == mae_pkg::FUNC_COEF) && row_ok && var_ok;
    const_we   = cmd.load && (in_func == mae_pkg::FUNC_CONST) && row_ok;
    point_we   = cmd.load && (in_func == mae_pkg::FUNC_POINT) && var_ok;
    coef_waddr = CA_W'((CA_W + 1)'(in_row) * (CA_W + 1)'(MAX_VARS) + (CA_W + 1)'(in_var));
  end

  mae_ram #(.WIDTH(mae_pkg::COEF_W), .DEPTH(MAX_ROWS * MAX_VARS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_data[mae_pkg::COEF_W-1:0]),
    .raddr (coef_raddr),
    .rdata (coef_rd)
  );

  mae_ram #(.WIDTH(mae_pkg::CONST_W), .DEPTH(MAX_ROWS)) u_const_ram (
    .clk   (clk),
    .we    (const_we),
    .waddr (RA_W'(in_row)),
    .wdata (in_data),
    .raddr (const_raddr),
    .rdata (const_rd)
  );

  mae_ram #(.WIDTH(mae_pkg::COEF_W), .DEPTH(MAX_VARS)) u_point_ram (
    .clk   (clk),
    .we    (point_we),
    .waddr (VA_W'(in_var)),
    .wdata (in_data[mae_pkg::COEF_W-1:0]),
    .raddr (point_raddr),
    .rdata (point_rd)
  );

  // Stage B: store data valid; Stage C: product; Stage D: accumulate
  mae_pkg::issue_t              tag_b_r, tag_c_r;
  logic                         vb_r, vc_r, done_d_r;
  logic signed [mae_pkg::PROD_W-1:0] prod_mul, prod_nxt, prod_r;
  logic [mae_pkg::CONST_W-1:0]  const_c_r;
  logic [RES_W-1:0]             acc_r, acc_nxt, base;
  logic [RES_W:0]               sum;
  logic                         first_row_d_r;
  logic [mae_pkg::ROW_CNT_W-1:0] row_d_r;
  logic [RES_W-1:0]             best_r;
  logic [mae_pkg::ROW_CNT_W-1:0] best_row_r;
  logic                         better;
  logic [RES_W-1:0]             result_r;
  logic [mae_pkg::BEST_W-1:0]   best_out_r;
  logic                         no_rows_r;

  // Product and saturating sum
  always_comb begin
    // signed product kept apart so the zero arm cannot make it unsigned
    prod_mul = $signed(coef_rd) * $signed(point_rd);
    prod_nxt = tag_b_r.zero_prod ? '0 : prod_mul;
    base     = tag_c_r.first ? {{(RES_W - mae_pkg::CONST_W){const_c_r[mae_pkg::CONST_W-1]}},
                                const_c_r}
                             : acc_r;
    sum      = {base[RES_W-1], base}
             + {{(RES_W + 1 - mae_pkg::PROD_W){prod_r[mae_pkg::PROD_W-1]}}, prod_r};
    if (sum[RES_W] != sum[RES_W-1]) begin
      acc_nxt = sum[RES_W] ? mae_pkg::RES_MIN : mae_pkg::RES_MAX;
    end else begin
      acc_nxt = sum[RES_W-1:0];
    end
    better = convex_mode ? ($signed(acc_r) > $signed(best_r))
                         : ($signed(acc_r) < $signed(best_r));
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r     <= 1'b0;
      vc_r     <= 1'b0;
      done_d_r <= 1'b0;
    end else begin
      vb_r     <= issue.valid;
      vc_r     <= vb_r;
      done_d_r <= vc_r && tag_c_r.last;
    end
  end

  // Pipeline payload, best tracking and result capture
  always_ff @(posedge clk) begin
    tag_b_r   <= issue;
    tag_c_r   <= tag_b_r;
    prod_r    <= prod_nxt;
    const_c_r <= const_rd;
    if (vc_r) begin
      acc_r         <= acc_nxt;
      first_row_d_r <= tag_c_r.first_row;
      row_d_r       <= tag_c_r.row;
    end
    // Row complete: lowest row wins ties, so only a strict gain replaces it
    if (done_d_r && (first_row_d_r || better)) begin
      best_r     <= acc_r;
      best_row_r <= row_d_r;
    end
    if (cmd.out_load) begin
      result_r   <= cmd.no_rows ? '0 : best_r;
      best_out_r <= cmd.no_rows ? '0 : best_row_r[mae_pkg::BEST_W-1:0];
      no_rows_r  <= cmd.no_rows;
    end
  end

  assign status.busy  = vb_r || vc_r || done_d_r;
  assign result_value = result_r;
  assign best_row     = best_out_r;
  assign no_rows      = no_rows_r;

endmodule
